### rtl/core/ifs_pkg.sv
// Shared types, constants and coefficient helpers for the IFS affine point generator.
// No dependencies; every other file of the block but ifs_queue imports this package.
`timescale 1ns / 1ps

package ifs_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int RANDOM_BITS_DEF = 16;

  localparam int RV_W      = 16;
  localparam int PIX_W     = 14;
  localparam int COL_W     = 8;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;

  localparam logic [CFG_W-1:0] CENTER_X_RESET = 12'd512;
  localparam logic [CFG_W-1:0] CENTER_Y_RESET = 12'd384;

  localparam int IN_DEPTH  = 2;
  localparam int OUT_DEPTH = 4;
  localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

  localparam int SCALE_K  = 600;
  localparam int OFFSET_X = 300;
  localparam int OFFSET_Y = 400;
  localparam int RED_K    = 500;
  localparam int GREEN_K  = 50;
  localparam int BLUE_K   = 30;

  localparam int NUM_MAPS  = 4;
  localparam int NUM_COEF  = 6;
  localparam int COEF_A    = 0;
  localparam int COEF_B    = 1;
  localparam int COEF_C    = 2;
  localparam int COEF_D    = 3;
  localparam int COEF_E    = 4;
  localparam int COEF_F    = 5;

  // coefficients in hundredths: a b c d e f
  localparam int MAP_COEF [NUM_MAPS][NUM_COEF] = '{
    '{60,   0,   0, 60, 18, 36},
    '{60,   0,   0, 60, 18, 12},
    '{40,  30, -30, 40, 27, 36},
    '{40, -30,  30, 40, 27,  9}
  };

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } result_t;

  // round half up on the magnitude, sign restored afterwards
  function automatic longint fix_coef(input int hundredths, input int frac_bits);
    longint mag;
    longint v;
    mag = (hundredths < 0) ? longint'(-hundredths) : longint'(hundredths);
    v = ((mag <<< frac_bits) + 64'sd50) / 64'sd100;
    return (hundredths < 0) ? -v : v;
  endfunction

endpackage

### rtl/core/ifs_queue.sv
// Small register queue with occupancy count.
// Depends on nothing; used between front and back and on the result side.
`timescale 1ns / 1ps

module ifs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (!do_push && do_pop) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

### rtl/core/ifs_front.sv
// Front end: takes input beats, picks the affine map and the green byte.
// Depends on ifs_pkg; writes into the work queue read by ifs_back.
`timescale 1ns / 1ps

module ifs_front import ifs_pkg::*; #(
  parameter int RANDOM_BITS = RANDOM_BITS_DEF,
  localparam int QW         = 2 + RANDOM_BITS + COL_W
) (
  input  logic            push,
  input  logic [RV_W-1:0] random_value,
  output logic            full,
  input  logic            q_full,
  output logic            q_push,
  output logic [QW-1:0]   q_data
);

  logic [RANDOM_BITS-1:0]       r;
  logic [1:0]                   sel;
  logic [RANDOM_BITS+COL_W-1:0] green_prod;
  logic [COL_W-1:0]             green;

  always_comb begin
    r          = RANDOM_BITS'(random_value);
    sel        = r[RANDOM_BITS-1 -: 2];
    green_prod = (RANDOM_BITS+COL_W)'(r) * (RANDOM_BITS+COL_W)'(GREEN_K);
    green      = green_prod[RANDOM_BITS +: COL_W];
  end

  assign full   = q_full;
  assign q_push = push && !q_full;
  assign q_data = {sel, r, green};

endmodule

### rtl/core/ifs_back.sv
// Back end: map update loop on the stored point, then pixel and colour stages.
// Depends on ifs_pkg; reads the work queue and writes the result queue.
`timescale 1ns / 1ps

module ifs_back import ifs_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int RANDOM_BITS = RANDOM_BITS_DEF,
  localparam int QW         = 2 + RANDOM_BITS + COL_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  logic [QW-1:0]     q_data,
  output logic              q_pop,
  input  logic [CFG_W-1:0]  center_x,
  input  logic [CFG_W-1:0]  center_y,
  input  logic [OCNT_W-1:0] out_count,
  output logic              out_push,
  output result_t           out_data
);

  localparam int PW   = FRAC_BITS + 4;
  localparam int CW   = FRAC_BITS + 1;
  localparam int PRW  = PW + CW;
  localparam int SW   = 2 * FRAC_BITS + 6;
  localparam int TW   = PW + 11;
  localparam int MW   = PW + RANDOM_BITS;
  localparam int RW   = MW + 9;
  localparam int BW   = MW + 5;
  localparam int SH   = FRAC_BITS + RANDOM_BITS;
  localparam int BUSY_W = OCNT_W + 1;

  localparam logic signed [SW-1:0] HALF_S = SW'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [SW-1:0] PMAX   = SW'((64'sd1 <<< (PW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] PMIN   = SW'(-(64'sd1 <<< (PW - 1)));
  localparam logic signed [TW-1:0] HALF_T = TW'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [TW-1:0] BIAS_T = TW'((64'sd1 <<< FRAC_BITS) - 64'sd1);

  logic signed [CW-1:0] coef_tab [NUM_MAPS][NUM_COEF];

  for (genvar m = 0; m < NUM_MAPS; m++) begin : g_map
    for (genvar k = 0; k < NUM_COEF; k++) begin : g_coef
      assign coef_tab[m][k] = CW'(fix_coef(MAP_COEF[m][k], FRAC_BITS));
    end
  end

  logic [1:0]             q_sel;
  logic [RANDOM_BITS-1:0] q_r;
  logic [COL_W-1:0]       q_green;

  logic signed [PW-1:0] point_x;
  logic signed [PW-1:0] point_y;

  logic                   v1;
  logic                   v2;
  logic                   v3;
  logic [BUSY_W-1:0]      busy;

  logic signed [PRW-1:0]  m_ax;
  logic signed [PRW-1:0]  m_by;
  logic signed [PRW-1:0]  m_cx;
  logic signed [PRW-1:0]  m_dy;
  logic signed [CW-1:0]   m_e;
  logic signed [CW-1:0]   m_f;
  logic [RANDOM_BITS-1:0] r1;
  logic [COL_W-1:0]       g1;

  logic [RANDOM_BITS-1:0] r2;
  logic [COL_W-1:0]       g2;

  logic signed [TW-1:0]   t_x;
  logic signed [TW-1:0]   t_y;
  logic [MW-1:0]          mr_x;
  logic [MW-1:0]          mr_y;
  logic                   neg_x;
  logic                   neg_y;
  logic [COL_W-1:0]       g3;

  logic signed [SW-1:0]   sum_x;
  logic signed [SW-1:0]   sum_y;
  logic signed [SW-1:0]   fl_x;
  logic signed [SW-1:0]   fl_y;
  logic signed [PW-1:0]   point_x_next;
  logic signed [PW-1:0]   point_y_next;

  logic [PW-1:0]          mag_x;
  logic [PW-1:0]          mag_y;

  logic signed [TW-1:0]   rnd_x;
  logic signed [TW-1:0]   rnd_y;
  logic [RW-1:0]          red_prod;
  logic [BW-1:0]          blue_prod;
  logic [COL_W-1:0]       red_q;
  logic [COL_W-1:0]       blue_q;

  assign {q_sel, q_r, q_green} = q_data;

  // reserve a result slot for every item in flight
  assign busy  = BUSY_W'(out_count) + BUSY_W'(v1) + BUSY_W'(v2) + BUSY_W'(v3);
  assign q_pop = !q_empty && !v1 && (busy < BUSY_W'(OUT_DEPTH));

  always_comb begin
    sum_x = SW'(m_ax) + SW'(m_by) + (SW'(m_e) <<< FRAC_BITS) + HALF_S;
    sum_y = SW'(m_cx) + SW'(m_dy) + (SW'(m_f) <<< FRAC_BITS) + HALF_S;
    fl_x  = sum_x >>> FRAC_BITS;
    fl_y  = sum_y >>> FRAC_BITS;
    priority if (fl_x > PMAX) begin
      point_x_next = PW'(PMAX);
    end else if (fl_x < PMIN) begin
      point_x_next = PW'(PMIN);
    end else begin
      point_x_next = PW'(fl_x);
    end
    priority if (fl_y > PMAX) begin
      point_y_next = PW'(PMAX);
    end else if (fl_y < PMIN) begin
      point_y_next = PW'(PMIN);
    end else begin
      point_y_next = PW'(fl_y);
    end
  end

  always_comb begin
    mag_x = point_x[PW-1] ? PW'(-point_x) : PW'(point_x);
    mag_y = point_y[PW-1] ? PW'(-point_y) : PW'(point_y);
  end

  always_comb begin
    rnd_x     = (t_x + (t_x[TW-1] ? BIAS_T : '0)) >>> FRAC_BITS;
    rnd_y     = (t_y + (t_y[TW-1] ? BIAS_T : '0)) >>> FRAC_BITS;
    red_prod  = RW'(mr_x) * RW'(RED_K);
    blue_prod = BW'(mr_y) * BW'(BLUE_K);
    red_q     = red_prod[SH +: COL_W];
    blue_q    = blue_prod[SH +: COL_W];
    out_data.pixel_x = PIX_W'(center_x) - PIX_W'(OFFSET_X) + rnd_x[PIX_W-1:0];
    out_data.pixel_y = PIX_W'(center_y) + PIX_W'(OFFSET_Y) - rnd_y[PIX_W-1:0];
    out_data.red     = neg_x ? COL_W'(-red_q) : red_q;
    out_data.green   = g3;
    out_data.blue    = neg_y ? COL_W'(-blue_q) : blue_q;
  end

  assign out_push = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      point_x <= '0;
      point_y <= '0;
    end else begin
      v1 <= q_pop;
      v2 <= v1;
      v3 <= v2;
      if (v1) begin
        point_x <= point_x_next;
        point_y <= point_y_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_ax <= coef_tab[q_sel][COEF_A] * point_x;
      m_by <= coef_tab[q_sel][COEF_B] * point_y;
      m_cx <= coef_tab[q_sel][COEF_C] * point_x;
      m_dy <= coef_tab[q_sel][COEF_D] * point_y;
      m_e  <= coef_tab[q_sel][COEF_E];
      m_f  <= coef_tab[q_sel][COEF_F];
      r1   <= q_r;
      g1   <= q_green;
    end
    if (v1) begin
      r2 <= r1;
      g2 <= g1;
    end
    if (v2) begin
      t_x   <= TW'(point_x) * TW'(SCALE_K) + HALF_T;
      t_y   <= TW'(point_y) * TW'(SCALE_K) + HALF_T;
      mr_x  <= MW'(mag_x) * MW'(r2);
      mr_y  <= MW'(mag_y) * MW'(r2);
      neg_x <= point_x[PW-1];
      neg_y <= point_y[PW-1];
      g3    <= g2;
    end
  end

endmodule

### rtl/core/ifs_affine_point_generator.sv
// Top level of the IFS affine point generator: config registers, queues, front and back.
// Depends on ifs_pkg, ifs_queue, ifs_front and ifs_back.
//
// Each input beat carries one random value; its top two bits pick one of four maple-leaf
// affine maps, the stored point is moved by that map, and one result beat follows with the
// screen pixel and three colour bytes. The back end takes a new item only once the last
// one is written back: a multiply step on the stored point and an add, round and saturate
// step that writes it back form the loop. An input passes the work queue, the multiply
// registers, the stored point, the scale and colour product registers and the result
// queue before it shows on the result ports. A 2-entry input queue and a 4-entry result
// queue let either side stall; center_x and center_y may be written only while idle.
`timescale 1ns / 1ps

module ifs_affine_point_generator import ifs_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    push,
  output logic                    full,
  input  logic [RV_W-1:0]         random_value,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [PIX_W-1:0] pixel_x,
  output logic signed [PIX_W-1:0] pixel_y,
  output logic [COL_W-1:0]        red,
  output logic [COL_W-1:0]        green,
  output logic [COL_W-1:0]        blue
);

  localparam int QW = 2 + RANDOM_BITS + COL_W;
  localparam int RQ = $bits(result_t);

  logic [CFG_W-1:0]  center_x;
  logic [CFG_W-1:0]  center_y;

  logic              wq_push;
  logic [QW-1:0]     wq_wdata;
  logic              wq_pop;
  logic [QW-1:0]     wq_rdata;
  logic              wq_full;
  logic              wq_empty;
  logic [$clog2(IN_DEPTH+1)-1:0] wq_count;

  logic              rq_push;
  result_t           rq_wdata;
  logic [RQ-1:0]     rq_rdata;
  logic              rq_full;
  logic [OCNT_W-1:0] rq_count;
  result_t           head;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= CENTER_X_RESET;
      center_y <= CENTER_Y_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X: center_x <= cfg_data;
        REG_CENTER_Y: center_y <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ifs_front #(
    .RANDOM_BITS (RANDOM_BITS)
  ) u_front (
    .push         (push),
    .random_value (random_value),
    .full         (full),
    .q_full       (wq_full),
    .q_push       (wq_push),
    .q_data       (wq_wdata)
  );

  ifs_queue #(
    .WIDTH (QW),
    .DEPTH (IN_DEPTH)
  ) u_work_q (
    .clk   (clk),
    .rst   (rst),
    .push  (wq_push),
    .wdata (wq_wdata),
    .pop   (wq_pop),
    .rdata (wq_rdata),
    .full  (wq_full),
    .empty (wq_empty),
    .count (wq_count)
  );

  ifs_back #(
    .FRAC_BITS   (FRAC_BITS),
    .RANDOM_BITS (RANDOM_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (wq_empty || (wq_count == '0)),
    .q_data    (wq_rdata),
    .q_pop     (wq_pop),
    .center_x  (center_x),
    .center_y  (center_y),
    .out_count (rq_count),
    .out_push  (rq_push),
    .out_data  (rq_wdata)
  );

  ifs_queue #(
    .WIDTH (RQ),
    .DEPTH (OUT_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rq_push),
    .wdata (rq_wdata),
    .pop   (pop),
    .rdata (rq_rdata),
    .full  (rq_full),
    .empty (empty),
    .count (rq_count)
  );

  assign head    = result_t'(rq_rdata);
  assign pixel_x = head.pixel_x;
  assign pixel_y = head.pixel_y;
  assign red     = head.red;
  assign green   = head.green;
  assign blue    = head.blue;

  logic unused_full;
  assign unused_full = rq_full;

endmodule

### rtl/core/ifs_checker.sv
// Port-level checks for the IFS affine point generator, bound to the top level.
// Depends on ifs_pkg and ifs_affine_point_generator.
`timescale 1ns / 1ps

module ifs_checker import ifs_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             push,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input logic [PIX_W-1:0] pixel_x,
  input logic [PIX_W-1:0] pixel_y,
  input logic [COL_W-1:0] red,
  input logic [COL_W-1:0] green,
  input logic [COL_W-1:0] blue
);

  a_reset_clear : assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not clear after reset");

  a_green_range : assert property (@(posedge clk) disable iff (rst)
    !empty |-> green < COL_W'(GREEN_K))
    else $error("green byte out of range");

  a_full_cause : assert property (@(posedge clk) disable iff (rst)
    !push |=> !$rose(full))
    else $error("full rose without an input beat");

  a_head_hold : assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(pixel_x) && $stable(pixel_y)
      && $stable(red) && $stable(green) && $stable(blue))
    else $error("waiting result beat changed");

endmodule

bind ifs_affine_point_generator ifs_checker u_ifs_checker (.*);
